### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the policy table sampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define MPTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle, outside reset.
`define MPTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/mpts_pkg.sv
// Package: types, constants and microcode program of the policy table sampler
`default_nettype none

package mpts_pkg;

   localparam int unsigned WEIGHT_W = 17;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned UPC_W    = 4;

   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'h10000;
   localparam logic [RATE_W-1:0]   RATE_RESET  = 16'd100;
   localparam logic [3:0]          DIV_LAST    = 4'd15;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_UPDATE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_IDLE,
      ACT_S_RD,
      ACT_S_CMP,
      ACT_DIV_INIT,
      ACT_DIV,
      ACT_U_RD,
      ACT_U_MOD,
      ACT_U_RDC,
      ACT_U_WRC,
      ACT_CLR
   } act_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_OP_SAMPLE,
      COND_OP_UPDATE,
      COND_OP_CLEAR,
      COND_S_MORE,
      COND_U_SKIP,
      COND_DIV_MORE,
      COND_U_MORE
   } cond_type;

   // Control word: action, jump condition and target, finish when no jump.
   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
      logic     fin;
   } uword_type;

   localparam upc_type UPC_IDLE   = 4'd0;
   localparam upc_type UPC_DISP_S = 4'd1;
   localparam upc_type UPC_DISP_U = 4'd2;
   localparam upc_type UPC_DISP_C = 4'd3;
   localparam upc_type UPC_S_RD   = 4'd4;
   localparam upc_type UPC_S_CMP  = 4'd5;
   localparam upc_type UPC_U_CHK  = 4'd6;
   localparam upc_type UPC_U_DIV  = 4'd7;
   localparam upc_type UPC_U_RD   = 4'd8;
   localparam upc_type UPC_U_MOD  = 4'd9;
   localparam upc_type UPC_U_RDC  = 4'd10;
   localparam upc_type UPC_U_WRC  = 4'd11;
   localparam upc_type UPC_CLR    = 4'd12;
   localparam upc_type UPC_DONE   = 4'd13;

   function automatic uword_type ucode(input upc_type upc);
      uword_type w;
      unique case (upc)
         UPC_IDLE:   w = '{ACT_IDLE,     COND_NO_START,  UPC_IDLE,  1'b0};
         UPC_DISP_S: w = '{ACT_NONE,     COND_OP_SAMPLE, UPC_S_RD,  1'b0};
         UPC_DISP_U: w = '{ACT_NONE,     COND_OP_UPDATE, UPC_U_CHK, 1'b0};
         UPC_DISP_C: w = '{ACT_NONE,     COND_OP_CLEAR,  UPC_CLR,   1'b1};
         UPC_S_RD:   w = '{ACT_S_RD,     COND_NEVER,     UPC_IDLE,  1'b0};
         UPC_S_CMP:  w = '{ACT_S_CMP,    COND_S_MORE,    UPC_S_CMP, 1'b1};
         UPC_U_CHK:  w = '{ACT_DIV_INIT, COND_U_SKIP,    UPC_DONE,  1'b0};
         UPC_U_DIV:  w = '{ACT_DIV,      COND_DIV_MORE,  UPC_U_DIV, 1'b0};
         UPC_U_RD:   w = '{ACT_U_RD,     COND_NEVER,     UPC_IDLE,  1'b0};
         UPC_U_MOD:  w = '{ACT_U_MOD,    COND_U_MORE,    UPC_U_MOD, 1'b0};
         UPC_U_RDC:  w = '{ACT_U_RDC,    COND_NEVER,     UPC_IDLE,  1'b0};
         UPC_U_WRC:  w = '{ACT_U_WRC,    COND_NEVER,     UPC_IDLE,  1'b1};
         UPC_CLR:    w = '{ACT_CLR,      COND_NEVER,     UPC_IDLE,  1'b1};
         UPC_DONE:   w = '{ACT_NONE,     COND_NEVER,     UPC_IDLE,  1'b1};
         default:    w = '{ACT_NONE,     COND_ALWAYS,    UPC_IDLE,  1'b0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mpts_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none

module mpts_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/markov_policy_table_sampler.sv
// Top level: microcoded policy table sampler with roulette-wheel sampling, updates and clears
// After accept, a sample walks k moves (1..NUM_MOVES) before the strobe; an update walks every move
//   and runs the divider unless it is ignored; a clear and an unused opcode also end in a strobe.
// busy stays high until the strobe; the next request is taken as busy drops.
// The cost is set by the one-read-per-cycle walk over the weight RAM and the 16-step divider.
// Reset: learning rate 100, every weight reads 65536/NUM_MOVES via per-state valid
//   bits cleared at once; no clearing pass. The receiver cannot stall the strobe.
`default_nettype none
`include "assert_macros.svh"

module markov_policy_table_sampler import mpts_pkg::*; #(
   parameter int NUM_MOVES  = 4,
   parameter int NUM_STATES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [2:0]        req_first_track,
   input  wire logic [2:0]        req_second_track,
   input  wire logic [15:0]       req_random_value,
   input  wire logic [1:0]        req_chosen_move,
   input  wire logic signed [7:0] req_adjustment,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_sampled_move,
   output logic                   rsp_fell_through,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data
);

   localparam int MW = $clog2(NUM_MOVES);
   localparam int RW = $clog2(NUM_STATES);
   localparam int AW = RW + MW;
   localparam int TW = WEIGHT_W + MW + 1;
   localparam logic [WEIGHT_W-1:0] INIT_WEIGHT = WEIGHT_W'(32'h10000 / NUM_MOVES);
   localparam logic [MW-1:0]       LAST_MOVE   = MW'(NUM_MOVES - 1);

   // state index modulo the state count
   logic [RW-1:0] row_lut [64];
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         row_lut[i] = RW'(i % NUM_STATES);
      end
   end

   upc_type                  upc_ff, upc_in;
   op_type                   op_ff, op_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [15:0]              rem_ff, rem_in;
   logic [MW-1:0]            chosen_ff, chosen_in;
   logic                     skip_ff, skip_in;
   logic                     neg_ff, neg_in;
   logic [7:0]               dmag_ff, dmag_in;
   logic [7:0]               drem_ff, drem_in;
   logic [RATE_W-1:0]        quo_ff, quo_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [MW-1:0]            move_ff, move_in;
   logic signed [TW-1:0]     total_ff, total_in;
   logic [MW-1:0]            pick_ff, pick_in;
   logic                     fell_ff, fell_in;
   logic [RATE_W-1:0]        lr_ff, lr_in;
   logic [NUM_STATES-1:0]    valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_move_ff, rsp_move_in;
   logic                     rsp_fell_ff, rsp_fell_in;

   uword_type                uw;
   logic                     cond_true;
   logic [WEIGHT_W-1:0]      ram_rdata, w_eff;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [WEIGHT_W-1:0]      ram_wdata;
   logic [MW-1:0]            rd_move;
   logic                     hit;
   logic [8:0]               div_r2;
   logic                     div_ge;
   logic [WEIGHT_W-1:0]      qx, room, take, give, new_w, sat_w;
   logic signed [TW-1:0]     delta, sum_c;

   assign uw    = ucode(upc_ff);
   assign w_eff = valid_ff[row_ff] ? ram_rdata : INIT_WEIGHT;
   assign hit   = {1'b0, rem_ff} < w_eff;

   // one restoring-division step
   assign div_r2 = {drem_ff, quo_ff[RATE_W-1]};
   assign div_ge = div_r2 >= {1'b0, dmag_ff};

   // per-move transfer, clamped to 0..65536
   assign qx    = {1'b0, quo_ff};
   assign room  = FULL_WEIGHT - w_eff;
   assign take  = (w_eff < qx) ? w_eff : qx;
   assign give  = (room < qx) ? room : qx;
   assign new_w = neg_ff ? (w_eff + give) : (w_eff - take);
   assign delta = neg_ff ? -$signed(TW'(give)) : $signed(TW'(take));

   assign sum_c = $signed(TW'(w_eff)) + total_ff;
   always_comb begin
      priority if (sum_c[TW-1]) begin
         sat_w = '0;
      end else if (sum_c > $signed(TW'(FULL_WEIGHT))) begin
         sat_w = FULL_WEIGHT;
      end else begin
         sat_w = sum_c[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      unique case (uw.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_START:  cond_true = !start;
         COND_OP_SAMPLE: cond_true = (op_ff == OP_SAMPLE);
         COND_OP_UPDATE: cond_true = (op_ff == OP_UPDATE);
         COND_OP_CLEAR:  cond_true = (op_ff == OP_CLEAR);
         COND_S_MORE:    cond_true = !hit && (move_ff != LAST_MOVE);
         COND_U_SKIP:    cond_true = skip_ff;
         COND_DIV_MORE:  cond_true = (cnt_ff != DIV_LAST);
         COND_U_MORE:    cond_true = (move_ff != LAST_MOVE);
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      row_in    = row_ff;
      rem_in    = rem_ff;
      chosen_in = chosen_ff;
      skip_in   = skip_ff;
      neg_in    = neg_ff;
      dmag_in   = dmag_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      move_in   = move_ff;
      total_in  = total_ff;
      pick_in   = pick_ff;
      fell_in   = fell_ff;
      valid_in  = valid_ff;
      rd_move   = move_ff;
      ram_we    = 1'b0;
      ram_waddr = {row_ff, move_ff};
      ram_wdata = new_w;

      unique case (uw.act)
         ACT_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_opcode);
               row_in    = row_lut[{req_second_track, req_first_track}];
               rem_in    = req_random_value;
               chosen_in = MW'(req_chosen_move);
               skip_in   = (req_adjustment == 8'sd0) ||
                           (32'(req_chosen_move) >= NUM_MOVES);
               neg_in    = req_adjustment[7];
               dmag_in   = req_adjustment[7] ? 8'(-req_adjustment) : 8'(req_adjustment);
               move_in   = '0;
               total_in  = '0;
               pick_in   = '0;
               fell_in   = 1'b0;
            end
         end
         ACT_S_RD: begin
            rd_move = move_ff;
         end
         ACT_S_CMP: begin
            rd_move = move_ff + MW'(1);
            priority if (hit) begin
               pick_in = move_ff;
            end else if (move_ff == LAST_MOVE) begin
               pick_in = LAST_MOVE;
               fell_in = 1'b1;
            end else begin
               rem_in  = rem_ff - w_eff[15:0];
               move_in = move_ff + MW'(1);
            end
         end
         ACT_DIV_INIT: begin
            quo_in  = lr_ff;
            drem_in = '0;
            cnt_in  = '0;
         end
         ACT_DIV: begin
            drem_in = div_ge ? 8'(div_r2 - {1'b0, dmag_ff}) : div_r2[7:0];
            quo_in  = {quo_ff[RATE_W-2:0], div_ge};
            cnt_in  = cnt_ff + 4'd1;
         end
         ACT_U_RD: begin
            rd_move = move_ff;
         end
         ACT_U_MOD: begin
            rd_move = move_ff + MW'(1);
            // leave the chosen move for the final pass
            if (move_ff != chosen_ff) begin
               ram_we   = 1'b1;
               total_in = total_ff + delta;
            end
            move_in = move_ff + MW'(1);
         end
         ACT_U_RDC: begin
            rd_move = chosen_ff;
         end
         ACT_U_WRC: begin
            ram_we           = 1'b1;
            ram_waddr        = {row_ff, chosen_ff};
            ram_wdata        = sat_w;
            valid_in[row_ff] = 1'b1;
         end
         ACT_CLR: begin
            valid_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign ram_raddr = {row_ff, rd_move};

   always_comb begin
      priority if (cond_true) begin
         upc_in = uw.target;
      end else if (uw.fin) begin
         upc_in = UPC_IDLE;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   assign rsp_valid_in = uw.fin && !cond_true;
   assign rsp_move_in  = 2'(pick_in);
   assign rsp_fell_in  = fell_in;
   assign lr_in        = csr_wr_en ? csr_wr_data : lr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         valid_ff     <= '0;
         lr_ff        <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         valid_ff     <= valid_in;
         lr_ff        <= lr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      rem_ff      <= rem_in;
      chosen_ff   <= chosen_in;
      skip_ff     <= skip_in;
      neg_ff      <= neg_in;
      dmag_ff     <= dmag_in;
      drem_ff     <= drem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      move_ff     <= move_in;
      total_ff    <= total_in;
      pick_ff     <= pick_in;
      fell_ff     <= fell_in;
      rsp_move_ff <= rsp_move_in;
      rsp_fell_ff <= rsp_fell_in;
   end

   mpts_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (2 ** AW)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy             = (upc_ff != UPC_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sampled_move = rsp_move_ff;
   assign rsp_fell_through = rsp_fell_ff;

   `MPTS_ASSERT_IMPL(a_rsp_after_work, clock, reset, rsp_valid_ff, $past(busy), "response without work")
   `MPTS_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted request not started")
   `MPTS_ASSERT_IMPL(a_fell_last, clock, reset, rsp_valid_ff && rsp_fell_ff, rsp_move_ff == 2'(LAST_MOVE), "fall-through not on last move")
   `MPTS_ASSERT_IMPL(a_div_rem, clock, reset, upc_ff == UPC_U_DIV, drem_ff < dmag_ff, "divider remainder out of range")
   `MPTS_ASSERT(a_clear_valid, clock, reset, (upc_ff == UPC_CLR) |=> (valid_ff == '0), "clear left a state valid")

endmodule

`default_nettype wire
